[sv/weighted_quantile_lookup_macros.svh]
// Assertion macros for the quantile lookup block.
`ifndef WEIGHTED_QUANTILE_LOOKUP_MACROS_SVH
`define WEIGHTED_QUANTILE_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
`define WQL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WQL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WQL_ASSERT_IMP(label, clk, rst, ante, cons)
`define WQL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/wql_pkg.sv]
`default_nettype none
package wql_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = AddrW + 1;
  localparam int SumW = 26;
  localparam logic [SumW-1:0] SumMax = '1;
  localparam int DivSteps = 58;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatDropped = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] mass;
    logic [15:0] weight;
    logic [16:0] probability;
  } in_item_t;

  typedef struct packed {
    logic [15:0] quantile_mass;
    logic [1:0] status;
  } out_item_t;

  // one cell of the restoring divider chain
  typedef struct packed {
    logic busy;
    logic [DivSteps-1:0] rem;
    logic [DivSteps-1:0] quo;
    logic [DivSteps-1:0] num;
  } div_link_t;
endpackage
`default_nettype wire

[sv/wql_div_cell.sv]
`default_nettype none
// One restoring division step; the row of cells passes partial state along.
module wql_div_cell (
  input wire logic clk,
  input wire logic rst,
  input wire logic [wql_pkg::DivSteps-1:0] den,
  input wire wql_pkg::div_link_t prev,
  output wql_pkg::div_link_t cur
);
  logic [wql_pkg::DivSteps:0] trial;
  logic [wql_pkg::DivSteps-1:0] shifted;

  always_comb begin
    shifted = {prev.rem[wql_pkg::DivSteps-2:0], prev.num[wql_pkg::DivSteps-1]};
    trial = {prev.rem[wql_pkg::DivSteps-1], shifted} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.busy <= 1'b0;
    end else begin
      cur.busy <= prev.busy;
    end
    cur.num <= {prev.num[wql_pkg::DivSteps-2:0], 1'b0};
    if (!trial[wql_pkg::DivSteps]) begin
      cur.rem <= trial[wql_pkg::DivSteps-1:0];
      cur.quo <= {prev.quo[wql_pkg::DivSteps-2:0], 1'b1};
    end else begin
      cur.rem <= shifted;
      cur.quo <= {prev.quo[wql_pkg::DivSteps-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

[sv/wql_divider.sv]
`default_nettype none
// Chain of division cells; quotient and remainder leave the last cell.
module wql_divider (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [wql_pkg::DivSteps-1:0] num,
  input wire logic [wql_pkg::DivSteps-1:0] den,
  output logic done,
  output logic [wql_pkg::DivSteps-1:0] quo,
  output logic [wql_pkg::DivSteps-1:0] rem
);
  wql_pkg::div_link_t link [wql_pkg::DivSteps+1];

  assign link[0].busy = start;
  assign link[0].rem = '0;
  assign link[0].quo = '0;
  assign link[0].num = num;

  for (genvar i = 0; i < wql_pkg::DivSteps; i++) begin : g_cell
    wql_div_cell u_cell (
      .clk(clk), .rst(rst), .den(den), .prev(link[i]), .cur(link[i+1])
    );
  end

  assign done = link[wql_pkg::DivSteps].busy;
  assign quo = link[wql_pkg::DivSteps].quo;
  assign rem = link[wql_pkg::DivSteps].rem;
endmodule
`default_nettype wire

[sv/weighted_quantile_lookup.sv]
`default_nettype none
// Channel | Direction | Payload
// in      | input     | in_item_t  (op, mass, weight, probability)
// out     | output    | out_item_t (quantile_mass, status)
// A clear ends on accept; an append runs S_APP_RD, S_APP_WAIT, S_APP_WR. An empty-table
// query is registered on accept; at p = 0, p >= 1 or one entry after S_Q_RDT, S_Q_WAITT.
// Else they fetch the total; a search step (ten at most) runs S_SRCH, S_SRCH_WAIT,
// S_SRCH_CMP; S_BR_L to S_PROD set up the bracket (equal ones end here), then the
// divider and S_DIV. Reset clears count and dropped flag; table contents stay undefined.
// One item at a time; in.stall is high while an item is at work or a result waits.
`include "weighted_quantile_lookup_macros.svh"
module weighted_quantile_lookup (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire wql_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output wql_pkg::out_item_t out_data
);
  localparam int AW = wql_pkg::AddrW;
  localparam int CW = wql_pkg::CountW;
  localparam int SW = wql_pkg::SumW;
  localparam int DW = wql_pkg::DivSteps;

  typedef enum logic [3:0] {
    S_IDLE, S_APP_RD, S_APP_WAIT, S_APP_WR, S_Q_RDT, S_Q_WAITT, S_SRCH,
    S_SRCH_WAIT, S_SRCH_CMP, S_BR_L, S_BR_R, S_BR_DONE, S_PROD, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic [15:0] mass_mem [wql_pkg::TableDepth];
  logic [SW-1:0] sum_mem [wql_pkg::TableDepth];
  logic [15:0] rd_mass;
  logic [SW-1:0] rd_sum;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_mass;
  logic [SW-1:0] wr_sum;

  logic [CW-1:0] count;
  logic dropped;
  wql_pkg::in_item_t item;
  logic [AW-1:0] lo, hi, mid;
  logic [42:0] target;
  logic [SW-1:0] sl, sr;
  logic [15:0] ml, mr;
  logic neg;
  logic [DW-1:0] num_abs, den;
  logic div_start;
  logic div_done;
  logic [DW-1:0] div_quo, div_rem;
  logic [SW:0] app_sum;
  logic [17:0] val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mass_mem[wr_addr] <= wr_mass;
      sum_mem[wr_addr] <= wr_sum;
    end
    rd_mass <= mass_mem[rd_addr];
    rd_sum <= sum_mem[rd_addr];
  end

  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign app_sum = {1'b0, wql_pkg::SumW'(item.weight)}
                   + ((count == '0) ? '0 : {1'b0, rd_sum});
  assign in_stall = (state != S_IDLE) || out_valid;

  wql_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num_abs), .den(den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  always_comb begin
    logic [DW-1:0] q;
    q = div_quo + ((neg && div_rem != '0) ? DW'(1) : DW'(0));
    if (neg) begin
      val = (q > DW'(ml)) ? 18'h20000 : 18'(ml) - 18'(q);
    end else begin
      val = (q > DW'(65535)) ? 18'h10000 : 18'(ml) + 18'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dropped <= 1'b0;
      out_valid <= 1'b0;
      wr_en <= 1'b0;
      div_start <= 1'b0;
    end else begin
      wr_en <= (state == S_APP_WR);
      div_start <= (state == S_PROD) && (sr > sl);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_data;
            case (in_data.op)
              wql_pkg::OpClear: begin
                count <= '0;
                dropped <= 1'b0;
              end
              wql_pkg::OpAppend: begin
                if (count == CW'(wql_pkg::TableDepth)) dropped <= 1'b1;
                else begin
                  rd_addr <= AW'(count - CW'(1));
                  state <= S_APP_RD;
                end
              end
              wql_pkg::OpQuery: begin
                if (count == '0) begin
                  out_data.quantile_mass <= '0;
                  out_data.status <= wql_pkg::StatEmpty;
                  out_valid <= 1'b1;
                end else begin
                  out_data.status <= dropped ? wql_pkg::StatDropped : wql_pkg::StatOk;
                  // last entry gives total and the answer at p >= 1; entry 0 serves p = 0
                  if (in_data.probability == '0 || count == CW'(1)) rd_addr <= '0;
                  else rd_addr <= AW'(count - CW'(1));
                  state <= S_Q_RDT;
                end
              end
              default: ;
            endcase
          end
        end
        S_APP_RD: state <= S_APP_WAIT;
        S_APP_WAIT: state <= S_APP_WR;
        S_APP_WR: begin
          wr_addr <= AW'(count);
          wr_mass <= item.mass;
          wr_sum <= app_sum[SW] ? wql_pkg::SumMax : app_sum[SW-1:0];
          count <= count + CW'(1);
          state <= S_IDLE;
        end
        S_Q_RDT: state <= S_Q_WAITT;
        S_Q_WAITT: begin
          target <= 43'(item.probability) * 43'(rd_sum);
          lo <= '0;
          hi <= AW'(count - CW'(1));
          if (item.probability[16] || item.probability == '0 || count == CW'(1)) begin
            out_data.quantile_mass <= rd_mass;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else state <= S_SRCH;
        end
        S_SRCH: begin
          if (AW'(hi - lo) > AW'(1)) begin
            rd_addr <= mid;
            state <= S_SRCH_WAIT;
          end else begin
            rd_addr <= lo;
            state <= S_BR_L;
          end
        end
        S_SRCH_WAIT: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if ({1'b0, rd_sum, 16'h0} <= target) lo <= mid;
          else hi <= mid;
          state <= S_SRCH;
        end
        S_BR_L: begin
          rd_addr <= hi;
          state <= S_BR_R;
        end
        S_BR_R: begin
          sl <= rd_sum;
          ml <= rd_mass;
          state <= S_BR_DONE;
        end
        S_BR_DONE: begin
          sr <= rd_sum;
          mr <= rd_mass;
          state <= S_PROD;
        end
        S_PROD: begin
          if (sr <= sl) begin
            out_data.quantile_mass <= ml;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            logic [43:0] d;
            logic [16:0] dmv;
            logic [43:0] nabs;
            logic [16:0] dm_abs;
            d = 44'(target) - {2'b0, sl, 16'h0};
            dmv = {1'b0, mr} - {1'b0, ml};
            nabs = d[43] ? -d : d;
            dm_abs = dmv[16] ? -dmv : dmv;
            num_abs <= DW'(nabs[41:0]) * DW'(dm_abs);
            neg <= (d[43] != dmv[16]) && (d != '0) && (dmv != '0);
            den <= DW'({sr - sl, 16'h0});
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_data.quantile_mass <= val[17] ? 16'h0 : (val[16] ? 16'hFFFF : val[15:0]);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WQL_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `WQL_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `WQL_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(wql_pkg::TableDepth))
endmodule
`default_nettype wire
